// ===== hdl/joystick_drive_command_decoder_unit_assert.svh =====
// Assertion macros for the joystick drive command decoder.
`ifndef JOYSTICK_DRIVE_COMMAND_DECODER_UNIT_ASSERT_SVH
`define JOYSTICK_DRIVE_COMMAND_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JDDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jddc assertion failed");

// Next-cycle implication, checked outside reset.
`define JDDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jddc assertion failed");

`endif

// ===== hdl/jddc_pkg.sv =====
package jddc_pkg;

    localparam int CFG_INDEX_W = 3;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ROBOT_MODE       = 3'd0;
    localparam cfg_index_t CFG_SLOW_SPEED       = 3'd1;
    localparam cfg_index_t CFG_SLOW_TURN_OFFSET = 3'd2;
    localparam cfg_index_t CFG_FAST_SPEED       = 3'd3;
    localparam cfg_index_t CFG_FAST_TURN_OFFSET = 3'd4;
    localparam cfg_index_t CFG_JOINT_SPEED      = 3'd5;
    localparam cfg_index_t CFG_SILENCE_LIMIT    = 3'd6;

    localparam int BT_L2 = 0;
    localparam int BT_L1 = 1;
    localparam int BT_R2 = 2;
    localparam int BT_R1 = 3;
    localparam int BT_RT = 4;
    localparam int BT_LT = 5;
    localparam int BT_DN = 6;
    localparam int BT_SE = 7;
    localparam int BT_ST = 8;
    localparam int BT_B4 = 9;
    localparam int BT_B3 = 10;
    localparam int BT_B2 = 11;
    localparam int BT_B1 = 12;
    localparam int BT_UP = 13;

    localparam int BUTTON_W = 14;
    localparam int GROUP_W  = 7;

    typedef logic [BUTTON_W-1:0] buttons_t;
    typedef logic signed [9:0] wheel_goal_t;
    typedef logic signed [8:0] joint_goal_t;

    localparam logic EVENT_BYTE = 1'b0;
    localparam logic EVENT_TICK = 1'b1;
    localparam logic MODE_WHEEL = 1'b0;
    localparam logic MODE_JOINT = 1'b1;

    localparam logic [7:0]  SLOW_SPEED_RESET       = 8'd64;
    localparam logic [7:0]  SLOW_TURN_OFFSET_RESET = 8'd16;
    localparam logic [7:0]  FAST_SPEED_RESET       = 8'd192;
    localparam logic [7:0]  FAST_TURN_OFFSET_RESET = 8'd48;
    localparam logic [7:0]  JOINT_SPEED_RESET      = 8'd128;
    localparam logic [15:0] SILENCE_LIMIT_RESET    = 16'd1000;
    localparam logic [15:0] QUIET_MAX              = 16'hFFFF;

endpackage

// ===== hdl/joystick_drive_command_decoder_unit.sv =====
// Joystick drive command decoder.
// Input channel (in_valid/in_ready): event_kind 0 carries a joystick byte in
// rx_byte, event_kind 1 is a one millisecond tick. Every item yields exactly one
// result item on the output channel (out_valid/out_ready) carrying the rover
// wheel goals, the six arm joint goals and the hold, override and link flags
// as they stand after that item.
// An item accepted at one edge is offered as a result from the next cycle on.
// Throughput is one item per cycle while no result waits on a stalled
// receiver; the state update is a single pass of logic from the ports into
// the state registers, which also serve as the result register.
// When the receiver stalls, the waiting result holds and in_ready drops; an
// item is taken in the same cycle that the waiting result is taken.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while idle,
// which the block does not enforce; indexes beyond the register list are ignored.
// Reset: all buttons released, goals zero, hold mode on, override and link off,
// quiet counter zero, registers at their default values, no result pending.
module joystick_drive_command_decoder_unit
    import jddc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     event_kind,
    input  logic [7:0]               rx_byte,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [9:0]        left_goal,
    output logic signed [9:0]        right_goal,
    output logic signed [8:0]        base_goal,
    output logic signed [8:0]        shoulder_goal,
    output logic signed [8:0]        elbow_goal,
    output logic signed [8:0]        wrist_a_goal,
    output logic signed [8:0]        wrist_b_goal,
    output logic signed [8:0]        grip_goal,
    output logic                     hold_mode,
    output logic                     override_flag,
    output logic                     link_alive,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]              cfg_wdata
);

`include "joystick_drive_command_decoder_unit_assert.svh"

    logic        mode_reg;
    logic [7:0]  slow_speed_reg;
    logic [7:0]  slow_off_reg;
    logic [7:0]  fast_speed_reg;
    logic [7:0]  fast_off_reg;
    logic [7:0]  joint_speed_reg;
    logic [15:0] limit_reg;

    buttons_t    buttons_reg, buttons_next;
    logic        prev_b4_reg, prev_b4_next;
    logic        hold_reg, hold_next;
    logic        ovr_reg, ovr_next;
    wheel_goal_t left_reg, left_next;
    wheel_goal_t right_reg, right_next;
    joint_goal_t joint_reg [6];
    joint_goal_t joint_next [6];
    logic [15:0] quiet_reg, quiet_next;
    logic        link_reg, link_next;
    logic        out_valid_reg;

    logic        in_accept;
    logic        fast;
    wheel_goal_t v;
    wheel_goal_t d;
    joint_goal_t s;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_WHEEL;
            slow_speed_reg  <= SLOW_SPEED_RESET;
            slow_off_reg    <= SLOW_TURN_OFFSET_RESET;
            fast_speed_reg  <= FAST_SPEED_RESET;
            fast_off_reg    <= FAST_TURN_OFFSET_RESET;
            joint_speed_reg <= JOINT_SPEED_RESET;
            limit_reg       <= SILENCE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROBOT_MODE:       mode_reg        <= cfg_wdata[0];
                CFG_SLOW_SPEED:       slow_speed_reg  <= cfg_wdata[7:0];
                CFG_SLOW_TURN_OFFSET: slow_off_reg    <= cfg_wdata[7:0];
                CFG_FAST_SPEED:       fast_speed_reg  <= cfg_wdata[7:0];
                CFG_FAST_TURN_OFFSET: fast_off_reg    <= cfg_wdata[7:0];
                CFG_JOINT_SPEED:      joint_speed_reg <= cfg_wdata[7:0];
                CFG_SILENCE_LIMIT:    limit_reg       <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    assign s = signed'({1'b0, joint_speed_reg});

    always_comb
    begin
        buttons_next = buttons_reg;
        prev_b4_next = prev_b4_reg;
        hold_next    = hold_reg;
        ovr_next     = ovr_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        for (int j = 0; j < 6; j++)
        begin
            joint_next[j] = joint_reg[j];
        end
        quiet_next   = quiet_reg;
        link_next    = link_reg;
        fast         = 1'b0;
        v            = '0;
        d            = '0;

        if (event_kind == EVENT_BYTE)
        begin
            if (rx_byte[7])
            begin
                buttons_next[BUTTON_W-1:GROUP_W] = rx_byte[GROUP_W-1:0];
            end
            else
            begin
                buttons_next[GROUP_W-1:0] = rx_byte[GROUP_W-1:0];
            end
            quiet_next = '0;
            link_next  = 1'b1;

            fast = buttons_next[BT_R2];
            v    = signed'({2'b00, fast ? fast_speed_reg : slow_speed_reg});
            d    = signed'({2'b00, fast ? fast_off_reg : slow_off_reg});

            if (mode_reg == MODE_WHEEL)
            begin
                ovr_next = buttons_next[BT_B2];
                if (buttons_next[BT_UP] && buttons_next[BT_LT])
                begin
                    left_next  = v - d;
                    right_next = v + d;
                end
                else if (buttons_next[BT_UP] && buttons_next[BT_RT])
                begin
                    left_next  = v + d;
                    right_next = v - d;
                end
                else if (buttons_next[BT_DN] && buttons_next[BT_LT])
                begin
                    left_next  = d - v;
                    right_next = -v - d;
                end
                else if (buttons_next[BT_DN] && buttons_next[BT_RT])
                begin
                    left_next  = -v - d;
                    right_next = d - v;
                end
                else if (buttons_next[BT_UP])
                begin
                    left_next  = v;
                    right_next = v;
                end
                else if (buttons_next[BT_DN])
                begin
                    left_next  = -v;
                    right_next = -v;
                end
                else if (buttons_next[BT_LT])
                begin
                    left_next  = -v;
                    right_next = v;
                end
                else if (buttons_next[BT_RT])
                begin
                    left_next  = v;
                    right_next = -v;
                end
                else
                begin
                    left_next  = '0;
                    right_next = '0;
                end
            end

            if (!prev_b4_reg && buttons_next[BT_B4])
            begin
                hold_next = !hold_reg;
            end
            prev_b4_next = buttons_next[BT_B4];

            if (mode_reg == MODE_JOINT)
            begin
                hold_next = 1'b1;
                if (buttons_next[BT_B1]) joint_next[5] = s;
                if (buttons_next[BT_B3]) joint_next[5] = -s;
                if (buttons_next[BT_RT])
                begin
                    joint_next[3] = s;
                    joint_next[4] = s;
                end
                if (buttons_next[BT_LT])
                begin
                    joint_next[3] = -s;
                    joint_next[4] = -s;
                end
                if (buttons_next[BT_UP])
                begin
                    joint_next[3] = -s;
                    joint_next[4] = s;
                end
                if (buttons_next[BT_DN])
                begin
                    joint_next[3] = s;
                    joint_next[4] = -s;
                end
                if (buttons_next[BT_L1]) joint_next[2] = -s;
                if (buttons_next[BT_L2]) joint_next[2] = s;
                if (buttons_next[BT_R1]) joint_next[1] = s;
                if (buttons_next[BT_R2]) joint_next[1] = -s;
                if (buttons_next[BT_B2]) joint_next[0] = -s;
                if (buttons_next[BT_B4]) joint_next[0] = s;
            end
        end
        else
        begin
            if (quiet_reg != QUIET_MAX)
            begin
                quiet_next = quiet_reg + 16'd1;
            end
            if (quiet_next > limit_reg)
            begin
                left_next  = '0;
                right_next = '0;
                link_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_reg <= '0;
            prev_b4_reg <= 1'b0;
            hold_reg    <= 1'b1;
            ovr_reg     <= 1'b0;
            left_reg    <= '0;
            right_reg   <= '0;
            for (int j = 0; j < 6; j++)
            begin
                joint_reg[j] <= '0;
            end
            quiet_reg   <= '0;
            link_reg    <= 1'b0;
        end
        else if (in_accept)
        begin
            buttons_reg <= buttons_next;
            prev_b4_reg <= prev_b4_next;
            hold_reg    <= hold_next;
            ovr_reg     <= ovr_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            for (int j = 0; j < 6; j++)
            begin
                joint_reg[j] <= joint_next[j];
            end
            quiet_reg   <= quiet_next;
            link_reg    <= link_next;
        end
    end

    // hold the result until taken; a new item refills the slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_goal     = left_reg;
    assign right_goal    = right_reg;
    assign base_goal     = joint_reg[0];
    assign shoulder_goal = joint_reg[1];
    assign elbow_goal    = joint_reg[2];
    assign wrist_a_goal  = joint_reg[3];
    assign wrist_b_goal  = joint_reg[4];
    assign grip_goal     = joint_reg[5];
    assign hold_mode     = hold_reg;
    assign override_flag = ovr_reg;
    assign link_alive    = link_reg;

    `JDDC_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid)
    `JDDC_ASSERT_NEXT(a_state_holds_when_idle, !in_accept,
                      $stable(hold_mode) && $stable(left_goal) && $stable(link_alive))
    `JDDC_ASSERT_NEXT(a_arm_forces_hold,
                      in_accept && event_kind == EVENT_BYTE && mode_reg == MODE_JOINT,
                      hold_mode)
    `JDDC_ASSERT_NEXT(a_dead_link_stays_quiet,
                      in_accept && event_kind == EVENT_TICK && !link_alive,
                      !link_alive && left_goal == 10'sd0 && right_goal == 10'sd0)
    `JDDC_ASSERT_NEXT(a_byte_wakes_link, in_accept && event_kind == EVENT_BYTE, link_alive)

endmodule
